// ===== rtl/cdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Concentric disk map package
// Shared constants and the control record that moves along the cell row.
// ----------------------------------------------------------------------------
package cdm_pkg;

  localparam int unsigned TRIG_Q = 30;
  localparam logic [29:0] PI_QUARTER_Q30 = 30'd843314857;
  localparam int unsigned DIV_CELLS = 31;

  typedef enum logic [3:0] {
    SEC_1 = 4'b0001,
    SEC_2 = 4'b0010,
    SEC_3 = 4'b0100,
    SEC_4 = 4'b1000
  } sector_t;

  typedef struct packed {
    logic    vld;
    logic    zero;
    logic    neg_q;
    sector_t sector;
  } ctl_t;

  // Divisors of the series terms, sine then cosine, for terms one to six.
  function automatic logic [7:0] sin_div(input logic [2:0] i);
    logic [7:0] k;
    begin
      k = 8'({i, 1'b0});
      sin_div = 8'(k * (k + 8'd1));
    end
  endfunction

  function automatic logic [7:0] cos_div(input logic [2:0] i);
    logic [7:0] k;
    begin
      k = 8'({i, 1'b0});
      cos_div = 8'((k - 8'd1) * k);
    end
  endfunction

  // Reciprocal for an exact floor division of a value below 2^TRIG_Q by c:
  // multiply by div_recip(c) and shift right by div_shift(c).
  function automatic int unsigned div_shift(input logic [7:0] c);
    begin
      div_shift = TRIG_Q + unsigned'($clog2(c));
    end
  endfunction

  function automatic logic [31:0] div_recip(input logic [7:0] c);
    logic [63:0] p;
    begin
      p = 64'(1) << div_shift(c);
      div_recip = 32'((p + 64'(c) - 64'd1) / 64'(c));
    end
  endfunction

endpackage

// ===== rtl/cdm_div_cell.sv =====
// ----------------------------------------------------------------------------
// Ratio division cell
// One restoring quotient bit per cell, passing remainder and quotient on.
// ----------------------------------------------------------------------------
module cdm_div_cell #(
  parameter int unsigned W = 18
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  cdm_pkg::ctl_t         ctl_i,
  input  logic [W-1:0]          rem_i,
  input  logic [W-1:0]          den_i,
  input  logic [cdm_pkg::DIV_CELLS-1:0] quo_i,
  output cdm_pkg::ctl_t         ctl_o,
  output logic [W-1:0]          rem_o,
  output logic [W-1:0]          den_o,
  output logic [cdm_pkg::DIV_CELLS-1:0] quo_o
);
  import cdm_pkg::*;

  logic [W:0] sh;
  logic [W:0] diff;
  logic [W-1:0] rem_nxt;
  logic         bit_nxt;
  ctl_t         ctl_r;
  logic [W-1:0] rem_r, den_r;
  logic [DIV_CELLS-1:0] quo_r;

  // The next dividend bit enters from the top of the quotient word.
  always_comb begin
    sh   = {rem_i, quo_i[DIV_CELLS-1]};
    diff = sh - {1'b0, den_i};
    bit_nxt = !diff[W];
    rem_nxt = bit_nxt ? diff[W-1:0] : sh[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r.vld <= ctl_i.vld;
    end
    if (en) begin
      ctl_r.zero   <= ctl_i.zero;
      ctl_r.neg_q  <= ctl_i.neg_q;
      ctl_r.sector <= ctl_i.sector;
      rem_r <= rem_nxt;
      den_r <= den_i;
      quo_r <= {quo_i[DIV_CELLS-2:0], bit_nxt};
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
  assign quo_o = quo_r;

endmodule

// ===== rtl/cdm_term_cell.sv =====
// ----------------------------------------------------------------------------
// Series term cell
// Advances the sine and cosine series by one term each.
// ----------------------------------------------------------------------------
module cdm_term_cell #(
  parameter int unsigned W = 17,
  parameter logic [2:0]  IDX = 3'd1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cdm_pkg::ctl_t        ctl_i,
  input  logic [W-1:0]         r_i,
  input  logic [31:0]          t2_i,
  input  logic [31:0]          st_i,
  input  logic [31:0]          ct_i,
  input  logic signed [33:0]   ss_i,
  input  logic signed [33:0]   cs_i,
  output cdm_pkg::ctl_t        ctl_o,
  output logic [W-1:0]         r_o,
  output logic [31:0]          t2_o,
  output logic [31:0]          st_o,
  output logic [31:0]          ct_o,
  output logic signed [33:0]   ss_o,
  output logic signed [33:0]   cs_o
);
  import cdm_pkg::*;

  localparam logic [7:0]  SIN_D  = sin_div(IDX);
  localparam logic [7:0]  COS_D  = cos_div(IDX);
  localparam int unsigned SIN_SH = div_shift(SIN_D);
  localparam int unsigned COS_SH = div_shift(COS_D);
  localparam logic [31:0] SIN_M  = div_recip(SIN_D);
  localparam logic [31:0] COS_M  = div_recip(COS_D);

  // Two stages: products, then divide-by-constant and accumulate.
  ctl_t ctl_a_r, ctl_b_r;
  logic [W-1:0] r_a_r, r_b_r;
  logic [31:0] t2_a_r, t2_b_r;
  logic [31:0] sp_r, cp_r;
  logic signed [33:0] ss_a_r, cs_a_r;
  logic [31:0] st_r, ct_r;
  logic signed [33:0] ss_r, cs_r;
  logic [63:0] sprod, cprod;
  logic [63:0] sq, cq;
  logic [31:0] st_nxt, ct_nxt;
  logic signed [33:0] ss_nxt, cs_nxt;

  always_comb begin
    sprod  = 64'(st_i) * 64'(t2_i);
    cprod  = 64'(ct_i) * 64'(t2_i);
    sq     = 64'(sp_r) * 64'(SIN_M);
    cq     = 64'(cp_r) * 64'(COS_M);
    st_nxt = 32'(sq >> SIN_SH);
    ct_nxt = 32'(cq >> COS_SH);
    if (IDX[0]) begin
      ss_nxt = ss_a_r - $signed({2'b00, st_nxt});
      cs_nxt = cs_a_r - $signed({2'b00, ct_nxt});
    end else begin
      ss_nxt = ss_a_r + $signed({2'b00, st_nxt});
      cs_nxt = cs_a_r + $signed({2'b00, ct_nxt});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r.vld <= 1'b0;
      ctl_b_r.vld <= 1'b0;
    end else if (en) begin
      ctl_a_r.vld <= ctl_i.vld;
      ctl_b_r.vld <= ctl_a_r.vld;
    end
    if (en) begin
      ctl_a_r.zero <= ctl_i.zero; ctl_a_r.neg_q <= ctl_i.neg_q;
      ctl_a_r.sector <= ctl_i.sector;
      ctl_b_r.zero <= ctl_a_r.zero; ctl_b_r.neg_q <= ctl_a_r.neg_q;
      ctl_b_r.sector <= ctl_a_r.sector;
      r_a_r <= r_i; r_b_r <= r_a_r;
      t2_a_r <= t2_i; t2_b_r <= t2_a_r;
      sp_r <= sprod[61:30];
      cp_r <= cprod[61:30];
      ss_a_r <= ss_i; cs_a_r <= cs_i;
      st_r <= st_nxt; ct_r <= ct_nxt;
      ss_r <= ss_nxt; cs_r <= cs_nxt;
    end
  end

  assign ctl_o = ctl_b_r;
  assign r_o = r_b_r;
  assign t2_o = t2_b_r;
  assign st_o = st_r;
  assign ct_o = ct_r;
  assign ss_o = ss_r;
  assign cs_o = cs_r;

endmodule

// ===== rtl/concentric_disk_map.sv =====
// ----------------------------------------------------------------------------
// Concentric disk map
// Maps a unit-square point to the unit disk through sector, ratio and series.
// ----------------------------------------------------------------------------
// The block accepts one request in every cycle in which in_ready is high
// and returns one result per request, in order. A request passes through
// a row of 31 division cells that form the ratio one quotient bit at a
// time, an angle stage, six series cells and an output stage before its
// result is presented. The whole row, and with it in_ready, advances only
// when the output register is empty or being drained, so a result that
// waits there holds every request in flight.
module concentric_disk_map #(
  parameter int unsigned IN_FRAC_BITS  = 16,
  parameter int unsigned OUT_FRAC_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [IN_FRAC_BITS-1:0]       in_square_u,
  input  logic [IN_FRAC_BITS-1:0]       in_square_v,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_FRAC_BITS:0] out_disk_x,
  output logic signed [OUT_FRAC_BITS:0] out_disk_y
);
  import cdm_pkg::*;

  localparam int unsigned AW = IN_FRAC_BITS + 2;
  localparam int unsigned RW = IN_FRAC_BITS + 1;
  localparam int unsigned SH = IN_FRAC_BITS + TRIG_Q - OUT_FRAC_BITS;
  localparam int unsigned PW = RW + 34;

  // The row holds while a result waits in the output register.
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  logic signed [AW-1:0] a, b, n, d;
  logic [RW-1:0] nm, dm;
  sector_t sec;
  ctl_t ctl0;

  always_comb begin
    a = $signed({1'b0, in_square_u, 1'b0}) - $signed(AW'(1) << IN_FRAC_BITS);
    b = $signed({1'b0, in_square_v, 1'b0}) - $signed(AW'(1) << IN_FRAC_BITS);
    if (a > -b) sec = (a > b) ? SEC_1 : SEC_2;
    else        sec = (a < b) ? SEC_3 : SEC_4;
    if (sec == SEC_1 || sec == SEC_3) begin n = b; d = a; end
    else begin n = a; d = b; end
    nm = RW'(n[AW-1] ? -n : n);
    dm = RW'(d[AW-1] ? -d : d);
    ctl0.vld = in_valid && en;
    ctl0.zero = (d == '0);
    ctl0.neg_q = n[AW-1] != d[AW-1] && n != '0;
    ctl0.sector = sec;
  end

  // Division row: the rounded ratio is the floor of (nm*2^30 + dm/2) / dm.
  // The top of the dividend starts as the remainder, and its low 31 bits
  // enter one per cell through the quotient word.
  ctl_t ctl_d [0:DIV_CELLS];
  logic [RW-1:0] rem_d [0:DIV_CELLS];
  logic [RW-1:0] den_d [0:DIV_CELLS];
  logic [DIV_CELLS-1:0] quo_d [0:DIV_CELLS];

  assign ctl_d[0] = ctl0;
  assign rem_d[0] = nm >> 1;
  assign den_d[0] = dm;
  assign quo_d[0] = {nm[0], TRIG_Q'(dm >> 1)};

  genvar gi;
  generate
    for (gi = 0; gi < DIV_CELLS; gi++) begin : g_div
      cdm_div_cell #(.W(RW)) u_cell (
        .clk(clk), .rst_n(rst_n), .en(en),
        .ctl_i(ctl_d[gi]),
        .rem_i(rem_d[gi]),
        .den_i(den_d[gi]),
        .quo_i(quo_d[gi]),
        .ctl_o(ctl_d[gi+1]),
        .rem_o(rem_d[gi+1]),
        .den_o(den_d[gi+1]),
        .quo_o(quo_d[gi+1])
      );
    end
  endgenerate

  // Angle: theta and t2 over two stages.
  ctl_t ctl_t1_r, ctl_t2_r;
  logic [RW-1:0] r_t1_r, r_t2_r;
  logic [31:0] th_r, t2_r, th2_r;
  logic [61:0] thp;
  logic [63:0] t2p;
  always_comb begin
    thp = 62'(quo_d[DIV_CELLS]) * 62'(PI_QUARTER_Q30) + (62'(1) << 29);
    t2p = 64'(th_r) * 64'(th_r) + (64'(1) << 29);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_t1_r.vld <= 1'b0; ctl_t2_r.vld <= 1'b0;
    end else if (en) begin
      ctl_t1_r.vld <= ctl_d[DIV_CELLS].vld; ctl_t2_r.vld <= ctl_t1_r.vld;
    end
    if (en) begin
      ctl_t1_r.zero <= ctl_d[DIV_CELLS].zero;
      ctl_t1_r.neg_q <= ctl_d[DIV_CELLS].neg_q;
      ctl_t1_r.sector <= ctl_d[DIV_CELLS].sector;
      ctl_t2_r.zero <= ctl_t1_r.zero; ctl_t2_r.neg_q <= ctl_t1_r.neg_q;
      ctl_t2_r.sector <= ctl_t1_r.sector;
      r_t1_r <= den_d[DIV_CELLS]; r_t2_r <= r_t1_r;
      th_r <= 32'(thp >> 30); th2_r <= th_r;
      t2_r <= 32'(t2p >> 30);
    end
  end

  ctl_t ctl_s [0:6];
  logic [RW-1:0] r_s [0:6];
  logic [31:0] t2_s [0:6];
  logic [31:0] st_s [0:6];
  logic [31:0] ct_s [0:6];
  logic signed [33:0] ss_s [0:6];
  logic signed [33:0] cs_s [0:6];
  assign ctl_s[0] = ctl_t2_r;
  assign r_s[0] = r_t2_r;
  assign t2_s[0] = t2_r;
  assign st_s[0] = th2_r;
  assign ct_s[0] = 32'(1) << 30;
  assign ss_s[0] = $signed({2'b00, th2_r});
  assign cs_s[0] = $signed(34'(1) << 30);

  generate
    for (gi = 0; gi < 6; gi++) begin : g_term
      cdm_term_cell #(.W(RW), .IDX(3'(gi + 1))) u_term (
        .clk(clk), .rst_n(rst_n), .en(en),
        .ctl_i(ctl_s[gi]), .r_i(r_s[gi]), .t2_i(t2_s[gi]),
        .st_i(st_s[gi]), .ct_i(ct_s[gi]), .ss_i(ss_s[gi]), .cs_i(cs_s[gi]),
        .ctl_o(ctl_s[gi+1]), .r_o(r_s[gi+1]), .t2_o(t2_s[gi+1]),
        .st_o(st_s[gi+1]), .ct_o(ct_s[gi+1]), .ss_o(ss_s[gi+1]),
        .cs_o(cs_s[gi+1])
      );
    end
  endgenerate

  // Output: select and scale.
  ctl_t ctl_o1_r;
  logic [PW-1:0] px_r, py_r;
  logic nx_r, ny_r;
  logic signed [34:0] c6, sv6, xv, yv;
  logic [33:0] xm, ym;
  always_comb begin
    c6 = 35'(cs_s[6]);
    sv6 = ctl_s[6].neg_q ? -35'(ss_s[6]) : 35'(ss_s[6]);
    unique case (ctl_s[6].sector)
      SEC_1: begin xv = c6;   yv = sv6;  end
      SEC_2: begin xv = sv6;  yv = c6;   end
      SEC_3: begin xv = -c6;  yv = -sv6; end
      default: begin xv = -sv6; yv = -c6; end
    endcase
    xm = 34'(xv[34] ? -xv : xv);
    ym = 34'(yv[34] ? -yv : yv);
  end

  logic [PW-1:0] qx, qy;
  logic signed [OUT_FRAC_BITS:0] ox, oy;
  localparam logic [PW-1:0] TOP = PW'(1) << OUT_FRAC_BITS;

  function automatic logic signed [OUT_FRAC_BITS:0] sat(
    input logic [PW-1:0] q, input logic ng);
    logic [PW-1:0] m;
    begin
      if (ng) begin
        m = (q > TOP) ? TOP : q;
        sat = (OUT_FRAC_BITS+1)'(-m);
      end else begin
        m = (q > TOP - PW'(1)) ? TOP - PW'(1) : q;
        sat = (OUT_FRAC_BITS+1)'(m);
      end
    end
  endfunction

  always_comb begin
    qx = (px_r + (PW'(1) << (SH - 1))) >> SH;
    qy = (py_r + (PW'(1) << (SH - 1))) >> SH;
    ox = ctl_o1_r.zero ? '0 : sat(qx, nx_r);
    oy = ctl_o1_r.zero ? '0 : sat(qy, ny_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o1_r.vld <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      ctl_o1_r.vld <= ctl_s[6].vld;
      out_valid <= ctl_o1_r.vld;
    end
    if (en) begin
      ctl_o1_r.zero <= ctl_s[6].zero;
      ctl_o1_r.neg_q <= ctl_s[6].neg_q;
      ctl_o1_r.sector <= ctl_s[6].sector;
      px_r <= PW'(r_s[6]) * PW'(xm);
      py_r <= PW'(r_s[6]) * PW'(ym);
      nx_r <= xv[34];
      ny_r <= yv[34];
      out_disk_x <= ox;
      out_disk_y <= oy;
    end
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Concentric disk map testbench
// Drives unit-square points through the valid/ready channel, partly with random gaps,
// predicts each disk point in fixed point and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class disk_scoreboard;
  localparam int unsigned IN_F = 16;
  localparam int unsigned OUT_F = 15;

  logic signed [15:0] exp_x_q[$];
  logic signed [15:0] exp_y_q[$];
  int errors = 0;
  int checked = 0;

  function automatic void series(input longint unsigned q, output longint c,
                                 output longint s);
    longint unsigned half, theta, t2, st, ct, k;
    int i;
    half = 64'd1 << 29;
    theta = (q * 64'd843314857 + half) >> 30;
    t2 = (theta * theta + half) >> 30;
    st = theta;
    ct = 64'd1 << 30;
    s = longint'(st);
    c = longint'(ct);
    for (i = 1; i <= 6; i++) begin
      k = 2 * i;
      st = ((st * t2) >> 30) / (k * (k + 1));
      ct = ((ct * t2) >> 30) / ((k - 1) * k);
      if (i % 2 == 1) begin
        s -= longint'(st);
        c -= longint'(ct);
      end else begin
        s += longint'(st);
        c += longint'(ct);
      end
    end
  endfunction

  function automatic logic signed [15:0] scale(input longint unsigned r, input longint v);
    longint unsigned m, q, top;
    int unsigned sh;
    sh = IN_F + 30 - OUT_F;
    top = 64'd1 << OUT_F;
    m = (v < 0) ? longint'(-v) : longint'(v);
    q = (r * m + (64'd1 << (sh - 1))) >> sh;
    if (v < 0) begin
      if (q > top) q = top;
      return 16'(-longint'(q));
    end
    if (q > top - 1) q = top - 1;
    return 16'(q);
  endfunction

  function void note_request(input logic [15:0] u, input logic [15:0] v);
    longint a, b, n, d, c, s, sv;
    longint unsigned r, nm, qm;
    int sector;
    logic signed [15:0] x, y;
    a = 2 * longint'(u) - 65536;
    b = 2 * longint'(v) - 65536;
    if (a > -b) sector = (a > b) ? 1 : 2;
    else sector = (a < b) ? 3 : 4;
    if (sector == 1 || sector == 3) begin
      n = b;
      d = a;
    end else begin
      n = a;
      d = b;
    end
    if (d == 0) begin
      x = 0;
      y = 0;
    end else begin
      r = (d < 0) ? -d : d;
      nm = (n < 0) ? -n : n;
      qm = ((nm << 30) + (r >> 1)) / r;
      series(qm, c, s);
      sv = ((n < 0) != (d < 0)) ? -s : s;
      case (sector)
        1: begin x = scale(r, c); y = scale(r, sv); end
        2: begin x = scale(r, sv); y = scale(r, c); end
        3: begin x = scale(r, -c); y = scale(r, -sv); end
        default: begin x = scale(r, -sv); y = scale(r, -c); end
      endcase
    end
    exp_x_q = {exp_x_q, x};
    exp_y_q = {exp_y_q, y};
  endfunction

  function void check_result(input logic signed [15:0] x, input logic signed [15:0] y);
    logic signed [15:0] ex, ey;
    if (exp_x_q.size() == 0) begin
      $error("disk point with no request outstanding: x=%0d y=%0d", x, y);
      errors++;
      return;
    end
    ex = exp_x_q.pop_front();
    ey = exp_y_q.pop_front();
    checked++;
    if (x !== ex) begin
      $error("disk_x: expected %0d, actual %0d", ex, x);
      errors++;
    end
    if (y !== ey) begin
      $error("disk_y: expected %0d, actual %0d", ey, y);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [15:0] in_square_u;
  logic [15:0] in_square_v;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_disk_x;
  logic signed [15:0] out_disk_y;

  disk_scoreboard board;
  int sent;
  bit sending_done;

  concentric_disk_map DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_square_u(in_square_u),
    .in_square_v(in_square_v),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_disk_x(out_disk_x),
    .out_disk_y(out_disk_y)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Called and returning at a falling edge; valid drops only for a gap.
  task automatic send_request(input logic [15:0] u, input logic [15:0] v, input bit gaps);
    int g;
    g = gaps ? gap_length() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_square_u <= u;
    in_square_v <= v;
    do @(posedge clk); while (!in_ready);
    board.note_request(u, v);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_burst(input int count, input bit gaps);
    int i;
    logic [15:0] u, v;
    for (i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: begin u = 16'($urandom); v = u; end
        1: begin u = 16'($urandom); v = 16'(17'h10000 - u); end
        2: begin u = 16'($urandom_range(0, 3)) + 16'h7ffe; v = 16'($urandom); end
        default: begin u = 16'($urandom); v = 16'($urandom); end
      endcase
      send_request(u, v, gaps);
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_square_u = '0;
    in_square_v = '0;
    sent = 0;
    sending_done = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    send_request(16'h8000, 16'h8000, 0);
    send_request(16'h0000, 16'h0000, 0);
    send_request(16'hffff, 16'hffff, 0);
    send_request(16'h0000, 16'hffff, 0);
    send_request(16'hffff, 16'h0000, 0);
    send_request(16'hffff, 16'h8000, 0);
    send_request(16'h8000, 16'hffff, 0);
    send_request(16'h0000, 16'h8000, 0);
    send_request(16'h8000, 16'h0000, 0);
    send_request(16'hc000, 16'h4000, 0);
    send_request(16'h4000, 16'hc000, 0);
    send_request(16'hc000, 16'hc000, 0);
    send_request(16'h4000, 16'h4000, 0);
    send_request(16'h8001, 16'h8000, 0);
    send_request(16'h7fff, 16'h8000, 0);
    send_request(16'h8000, 16'h7fff, 0);
    send_request(16'haaaa, 16'h5555, 0);
    send_request(16'h5555, 16'haaaa, 0);
    send_request(16'hfffe, 16'h8001, 0);
    send_request(16'h0001, 16'h7fff, 0);
    send_burst(250, 0);
    send_burst(480, 1);
    in_valid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (($urandom_range(0, 999) / 250) == 0 && $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 1) == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (gap_length()) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_disk_x, out_disk_y);
    end
  end

  initial begin
    wait (sending_done);
    while (board.exp_x_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Checked %0d disk points from %0d requests, covering all four sectors,",
             board.checked, sent);
    $display("the origin, the square's corners and edges, and random stalls on both sides.");
    if (board.errors == 0 && board.exp_x_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end
endmodule
